[rtl/core/bcde_pkg.sv]
// Package with the shared types and constants of the bike computer display engine.
`default_nettype none
package bcde_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV_DIST,
        ST_DIST_DONE,
        ST_SPD_LOAD,
        ST_DIV_SPD,
        ST_SPD_DONE,
        ST_DIV_CAD,
        ST_CAD_DONE,
        ST_DIV_HR,
        ST_HR_DONE,
        ST_DIV_MIN,
        ST_MIN_DONE,
        ST_BCD_A,
        ST_FORMAT,
        ST_BCD_B,
        ST_FMT_MIN,
        ST_DONE
    } t_state;

    localparam logic [3:0]  MODE_ODO     = 4'hA;
    localparam logic [3:0]  MODE_DUR     = 4'hB;
    localparam logic [3:0]  MODE_SPD     = 4'hC;
    localparam logic [3:0]  MODE_CAD     = 4'hD;
    localparam logic [3:0]  MODE_SET     = 4'hE;

    localparam logic [11:0] GIRTH_RST    = 12'd2136;
    localparam logic [11:0] WHEEL_RST    = 12'h700;

    localparam logic [15:0] DIST_DIV     = 16'd10000;
    localparam logic [15:0] SEC_PER_HR   = 16'd3600;
    localparam logic [15:0] SEC_PER_MIN  = 16'd60;
    localparam logic [21:0] SPD_SCALE    = 22'd3600000;
    localparam logic [15:0] CAD_SCALE    = 16'd60000;
    localparam logic [13:0] VAL_MAX      = 14'd9999;
    localparam logic [13:0] CAD_MAX      = 14'd999;
    localparam logic [13:0] CAD_SAT      = 14'd995;

endpackage
`default_nettype wire

[rtl/core/bike_computer_display_engine_top.sv]
// Top level of the bike computer display engine: event decoding, serial divider and BCD converter.
`default_nettype none
// One item is taken at a time. A refresh divides to get the distance; odometer mode then
// converts it to BCD, speed and cadence modes divide again and convert, duration mode divides
// into hours and minutes and converts both. With a zero short interval speed and cadence skip
// their second division. Setting and digit items go straight to the output stage. The next item
// can be accepted once the result is loaded. The steps use the one bit-serial restoring divider
// (one quotient bit per cycle, 12 to 36 bits per division) and the bit-serial BCD converter.
// A finished result waits in the output register while the next item is already accepted; a
// result that cannot be loaded because the output register is still held stalls the input.
module bike_computer_display_engine_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [11:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic        i_btn_setting,
    input  wire logic        i_btn_trip,
    input  wire logic        i_btn_mode,
    input  wire logic        i_btn_night,
    input  wire logic [19:0] i_fork_count,
    input  wire logic [9:0]  i_crank_count,
    input  wire logic [23:0] i_time_long_s,
    input  wire logic [15:0] i_time_short_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_display_mode,
    output logic [15:0]      o_int_bcd,
    output logic [7:0]       o_frac_bcd,
    output logic             o_clear_wheel_cnt,
    output logic             o_clear_trip_time,
    output logic             o_night_on
);

    bcde_pkg::t_state r_state, n_state;

    logic [11:0] r_girth;
    logic [3:0]  r_mode, n_mode;
    logic        r_night, n_night;
    logic [13:0] r_last_dist, n_last_dist;
    logic [23:0] r_prev_time, n_prev_time;
    logic        r_edit, n_edit;
    logic [1:0]  r_dpos, n_dpos;
    logic [11:0] r_wheel, n_wheel;

    logic [9:0]  r_crank, n_crank;
    logic [23:0] r_tlong, n_tlong;
    logic [15:0] r_ms, n_ms;
    logic        r_clr, n_clr;
    logic [13:0] r_dist, n_dist;
    logic [13:0] r_dd, n_dd;
    logic        r_up, n_up;
    logic        r_round, n_round;
    logic [3:0]  r_res_mode, n_res_mode;
    logic [15:0] r_int, n_int;
    logic [7:0]  r_frac, n_frac;

    logic [16:0] r_rem, n_rem;
    logic [35:0] r_quo, n_quo;
    logic [15:0] r_div, n_div;
    logic [5:0]  r_cnt, n_cnt;
    logic [13:0] r_bin, n_bin;
    logic [15:0] r_bcd, n_bcd;

    logic        r_ovalid, n_ovalid;
    logic [3:0]  r_o_mode, n_o_mode;
    logic [15:0] r_o_int, n_o_int;
    logic [7:0]  r_o_frac, n_o_frac;
    logic        r_o_clr, n_o_clr;
    logic        r_o_night, n_o_night;

    logic        accept;
    logic [16:0] rem_sh;
    logic        div_ge;
    logic [16:0] rem_step;
    logic [35:0] quo_step;
    logic [15:0] bcd_adj;
    logic [15:0] bcd_step;
    logic [13:0] bin_step;
    logic [19:0] fork_sel;
    logic [31:0] dist_prod;
    logic [13:0] dist_val;
    logic [23:0] tlong_eff;
    logic [3:0]  dig_h, dig_t, dig_o;
    logic [3:0]  rnd_h, rnd_t;
    logic        do_refresh;
    logic        out_free;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != bcde_pkg::ST_IDLE);
    assign out_free   = !r_ovalid || !i_out_stall;

    assign rem_sh   = {r_rem[15:0], r_quo[35]};
    assign div_ge   = (rem_sh >= {1'b0, r_div});
    assign rem_step = div_ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
    assign quo_step = {r_quo[34:0], div_ge};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? (r_bcd[4*k +: 4] + 4'd3)
                                                           : r_bcd[4*k +: 4];
        end
    end
    assign bcd_step = {bcd_adj[14:0], r_bin[13]};
    assign bin_step = {r_bin[12:0], 1'b0};

    assign dig_h = r_bcd[11:8];
    assign dig_t = r_bcd[7:4];
    assign dig_o = r_bcd[3:0];

    always_comb begin
        rnd_h = dig_h;
        rnd_t = dig_t;
        if (dig_o >= 4'd5) begin
            if (dig_t == 4'd9) begin
                rnd_t = 4'd0;
                rnd_h = dig_h + 4'd1;
            end else begin
                rnd_t = dig_t + 4'd1;
            end
        end
    end

    assign dist_val = (r_quo[31:0] >= {18'd0, bcde_pkg::VAL_MAX}) ? bcde_pkg::VAL_MAX
                                                                  : (r_quo[13:0] + 14'd1);
    assign tlong_eff = (dist_val == r_last_dist) ? r_prev_time : r_tlong;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_night     = r_night;
        n_last_dist = r_last_dist;
        n_prev_time = r_prev_time;
        n_edit      = r_edit;
        n_dpos      = r_dpos;
        n_wheel     = r_wheel;
        n_crank     = r_crank;
        n_tlong     = r_tlong;
        n_ms        = r_ms;
        n_clr       = r_clr;
        n_dist      = r_dist;
        n_dd        = r_dd;
        n_up        = r_up;
        n_round     = r_round;
        n_res_mode  = r_res_mode;
        n_int       = r_int;
        n_frac      = r_frac;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_ovalid    = r_ovalid && i_out_stall;
        n_o_mode    = r_o_mode;
        n_o_int     = r_o_int;
        n_o_frac    = r_o_frac;
        n_o_clr     = r_o_clr;
        n_o_night   = r_o_night;
        do_refresh  = 1'b0;
        fork_sel    = i_fork_count;
        dist_prod   = 32'd0;

        case (r_state)
            bcde_pkg::ST_IDLE: begin
                if (accept) begin
                    n_clr = 1'b0;
                    if (r_edit) begin
                        if (i_req_type && i_btn_mode) begin
                            if (r_dpos == 2'd2) begin
                                n_edit     = 1'b0;
                                n_dpos     = 2'd0;
                                do_refresh = 1'b1;
                            end else begin
                                n_dpos = r_dpos + 2'd1;
                            end
                        end else if (i_req_type && i_btn_trip) begin
                            case (r_dpos)
                                2'd0: n_wheel[11:8] = (r_wheel[11:8] == 4'd9) ? 4'd0
                                                      : (r_wheel[11:8] + 4'd1);
                                2'd1: n_wheel[7:4]  = (r_wheel[7:4] == 4'd9) ? 4'd0
                                                      : (r_wheel[7:4] + 4'd1);
                                default: n_wheel[3:0] = (r_wheel[3:0] == 4'd9) ? 4'd0
                                                        : (r_wheel[3:0] + 4'd1);
                            endcase
                            n_int      = {4'd0, n_wheel};
                            n_frac     = 8'd0;
                            n_res_mode = bcde_pkg::MODE_SET;
                            n_state    = bcde_pkg::ST_DONE;
                        end
                    end else if (i_req_type && i_btn_setting) begin
                        n_edit     = 1'b1;
                        n_dpos     = 2'd0;
                        n_int      = {4'd0, r_wheel};
                        n_frac     = 8'd0;
                        n_res_mode = bcde_pkg::MODE_SET;
                        n_state    = bcde_pkg::ST_DONE;
                    end else begin
                        do_refresh = 1'b1;
                        if (i_req_type && i_btn_trip) begin
                            n_clr = 1'b1;
                        end else if (i_req_type && i_btn_mode) begin
                            n_mode = (r_mode == bcde_pkg::MODE_CAD) ? bcde_pkg::MODE_ODO
                                                                    : (r_mode + 4'd1);
                        end else if (i_req_type && i_btn_night) begin
                            n_night = !r_night;
                        end
                    end
                    if (do_refresh) begin
                        fork_sel   = n_clr ? 20'd0 : i_fork_count;
                        dist_prod  = {12'd0, fork_sel} * {20'd0, r_girth};
                        n_tlong    = n_clr ? 24'd0 : i_time_long_s;
                        n_crank    = i_crank_count;
                        n_ms       = i_time_short_ms;
                        n_res_mode = n_mode;
                        n_quo      = {dist_prod, 4'd0};
                        n_rem      = 17'd0;
                        n_div      = bcde_pkg::DIST_DIV;
                        n_cnt      = 6'd31;
                        n_state    = bcde_pkg::ST_DIV_DIST;
                    end
                end
            end

            bcde_pkg::ST_DIV_DIST, bcde_pkg::ST_DIV_SPD, bcde_pkg::ST_DIV_CAD,
            bcde_pkg::ST_DIV_HR, bcde_pkg::ST_DIV_MIN: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    case (r_state)
                        bcde_pkg::ST_DIV_DIST: n_state = bcde_pkg::ST_DIST_DONE;
                        bcde_pkg::ST_DIV_SPD:  n_state = bcde_pkg::ST_SPD_DONE;
                        bcde_pkg::ST_DIV_CAD:  n_state = bcde_pkg::ST_CAD_DONE;
                        bcde_pkg::ST_DIV_HR:   n_state = bcde_pkg::ST_HR_DONE;
                        default:               n_state = bcde_pkg::ST_MIN_DONE;
                    endcase
                end
            end

            bcde_pkg::ST_DIST_DONE: begin
                n_dist      = dist_val;
                n_up        = (dist_val > r_last_dist);
                n_dd        = (dist_val > r_last_dist) ? (dist_val - r_last_dist) : 14'd0;
                n_last_dist = dist_val;
                n_prev_time = tlong_eff;
                n_tlong     = tlong_eff;
                n_round     = 1'b0;
                n_bcd       = 16'd0;
                n_rem       = 17'd0;
                case (r_mode)
                    bcde_pkg::MODE_ODO: begin
                        n_bin   = dist_val;
                        n_cnt   = 6'd13;
                        n_state = bcde_pkg::ST_BCD_A;
                    end
                    bcde_pkg::MODE_DUR: begin
                        n_quo   = {tlong_eff, 12'd0};
                        n_div   = bcde_pkg::SEC_PER_HR;
                        n_cnt   = 6'd23;
                        n_state = bcde_pkg::ST_DIV_HR;
                    end
                    bcde_pkg::MODE_SPD: begin
                        n_state = bcde_pkg::ST_SPD_LOAD;
                    end
                    default: begin
                        if (r_ms == 16'd0) begin
                            n_bin   = bcde_pkg::CAD_MAX;
                            n_cnt   = 6'd13;
                            n_state = bcde_pkg::ST_BCD_A;
                        end else begin
                            n_quo   = {({16'd0, r_crank} * {10'd0, bcde_pkg::CAD_SCALE}),
                                       10'd0};
                            n_div   = r_ms;
                            n_cnt   = 6'd25;
                            n_state = bcde_pkg::ST_DIV_CAD;
                        end
                    end
                endcase
            end

            bcde_pkg::ST_SPD_LOAD: begin
                if (r_ms == 16'd0) begin
                    n_bin   = r_up ? bcde_pkg::VAL_MAX : 14'd0;
                    n_cnt   = 6'd13;
                    n_state = bcde_pkg::ST_BCD_A;
                end else begin
                    n_quo   = {22'd0, r_dd} * {14'd0, bcde_pkg::SPD_SCALE};
                    n_div   = r_ms;
                    n_cnt   = 6'd35;
                    n_state = bcde_pkg::ST_DIV_SPD;
                end
            end

            bcde_pkg::ST_SPD_DONE: begin
                n_bin   = (r_quo >= {22'd0, bcde_pkg::VAL_MAX}) ? bcde_pkg::VAL_MAX
                                                               : r_quo[13:0];
                n_cnt   = 6'd13;
                n_state = bcde_pkg::ST_BCD_A;
            end

            bcde_pkg::ST_CAD_DONE: begin
                if (r_quo >= {22'd0, bcde_pkg::CAD_SAT}) begin
                    n_bin   = bcde_pkg::CAD_MAX;
                end else begin
                    n_bin   = r_quo[13:0];
                    n_round = 1'b1;
                end
                n_cnt   = 6'd13;
                n_state = bcde_pkg::ST_BCD_A;
            end

            bcde_pkg::ST_HR_DONE: begin
                n_dist  = r_quo[13:0];
                n_quo   = {r_rem[11:0], 24'd0};
                n_rem   = 17'd0;
                n_div   = bcde_pkg::SEC_PER_MIN;
                n_cnt   = 6'd11;
                n_state = bcde_pkg::ST_DIV_MIN;
            end

            bcde_pkg::ST_MIN_DONE: begin
                n_dd    = r_quo[13:0];
                n_bin   = r_dist;
                n_cnt   = 6'd13;
                n_state = bcde_pkg::ST_BCD_A;
            end

            bcde_pkg::ST_BCD_A, bcde_pkg::ST_BCD_B: begin
                n_bcd = bcd_step;
                n_bin = bin_step;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = (r_state == bcde_pkg::ST_BCD_A) ? bcde_pkg::ST_FORMAT
                                                              : bcde_pkg::ST_FMT_MIN;
                end
            end

            bcde_pkg::ST_FORMAT: begin
                case (r_mode)
                    bcde_pkg::MODE_DUR: begin
                        n_int   = r_bcd;
                        n_bin   = r_dd;
                        n_bcd   = 16'd0;
                        n_cnt   = 6'd13;
                        n_state = bcde_pkg::ST_BCD_B;
                    end
                    bcde_pkg::MODE_CAD: begin
                        n_int   = r_round ? {4'd0, rnd_h, rnd_t, 4'd0} : r_bcd;
                        n_frac  = 8'd0;
                        n_state = bcde_pkg::ST_DONE;
                    end
                    default: begin
                        n_int   = {8'd0, r_bcd[15:8]};
                        n_frac  = r_bcd[7:0];
                        n_state = bcde_pkg::ST_DONE;
                    end
                endcase
            end

            bcde_pkg::ST_FMT_MIN: begin
                n_frac  = r_bcd[7:0];
                n_state = bcde_pkg::ST_DONE;
            end

            bcde_pkg::ST_DONE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_o_mode  = r_res_mode;
                    n_o_int   = r_int;
                    n_o_frac  = r_frac;
                    n_o_clr   = r_clr;
                    n_o_night = r_night;
                    n_state   = bcde_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bcde_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bcde_pkg::ST_IDLE;
            r_girth     <= bcde_pkg::GIRTH_RST;
            r_mode      <= bcde_pkg::MODE_ODO;
            r_night     <= 1'b0;
            r_last_dist <= 14'd0;
            r_prev_time <= 24'd0;
            r_edit      <= 1'b0;
            r_dpos      <= 2'd0;
            r_wheel     <= bcde_pkg::WHEEL_RST;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_girth <= i_cfg_wdata;
            end
            r_mode      <= n_mode;
            r_night     <= n_night;
            r_last_dist <= n_last_dist;
            r_prev_time <= n_prev_time;
            r_edit      <= n_edit;
            r_dpos      <= n_dpos;
            r_wheel     <= n_wheel;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crank    <= n_crank;
        r_tlong    <= n_tlong;
        r_ms       <= n_ms;
        r_clr      <= n_clr;
        r_dist     <= n_dist;
        r_dd       <= n_dd;
        r_up       <= n_up;
        r_round    <= n_round;
        r_res_mode <= n_res_mode;
        r_int      <= n_int;
        r_frac     <= n_frac;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_div      <= n_div;
        r_cnt      <= n_cnt;
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_o_mode   <= n_o_mode;
        r_o_int    <= n_o_int;
        r_o_frac   <= n_o_frac;
        r_o_clr    <= n_o_clr;
        r_o_night  <= n_o_night;
    end

    assign o_out_valid       = r_ovalid;
    assign o_display_mode    = r_o_mode;
    assign o_int_bcd         = r_o_int;
    assign o_frac_bcd        = r_o_frac;
    assign o_clear_wheel_cnt = r_o_clr;
    assign o_clear_trip_time = r_o_clr;
    assign o_night_on        = r_o_night;

endmodule
`default_nettype wire

[tb/sv/bike_computer_display_engine_top_tb.sv]
// Self-checking testbench for the bike computer display engine: random and directed events.
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] ibcd;
    logic [7:0]  fbcd;
    logic        clr_fork;
    logic        clr_trip;
    logic        night;
} disp_t;

typedef struct packed {
    logic        req;
    logic        set;
    logic        trip;
    logic        mode;
    logic        night;
    logic [19:0] fork_cnt;
    logic [9:0]  crank;
    logic [23:0] tlong;
    logic [15:0] tshort;
} event_t;

class display_scoreboard;
    disp_t       pending[$];
    int          errors;
    logic [11:0] girth;
    logic [3:0]  mode_r;
    logic        night_r;
    logic [13:0] last_dist;
    logic [23:0] prev_time;
    logic        editing;
    logic [1:0]  digit;
    int          wheel;

    function new();
        errors = 0;
        girth = bcde_pkg::GIRTH_RST;
        mode_r = bcde_pkg::MODE_ODO;
        night_r = 0;
        last_dist = 0;
        prev_time = 0;
        editing = 0;
        digit = 0;
        wheel = 700;
    endfunction

    function logic [15:0] bcd4(int v);
        logic [15:0] r;
        r = 0;
        for (int k = 0; k < 4; k++) begin
            r[4*k +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return r;
    endfunction

    function void push(logic [3:0] m, int iv, int fv, logic clr);
        disp_t d;
        logic [15:0] fb;
        fb = bcd4(fv);
        d.mode = m;
        d.ibcd = bcd4(iv);
        d.fbcd = fb[7:0];
        d.clr_fork = clr;
        d.clr_trip = clr;
        d.night = night_r;
        pending.push_back(d);
    endfunction

    function void display_refresh(event_t e, logic clr);
        longint fork_v, dist_v, dd, s, c, c5;
        int tl, ms, spd, cad, iv, fv;
        logic up;
        fork_v = clr ? 0 : e.fork_cnt;
        tl = clr ? 0 : e.tlong;
        ms = e.tshort;
        dist_v = fork_v * girth / 10000 + 1;
        if (dist_v > 9999) dist_v = 9999;
        up = dist_v > last_dist;
        dd = up ? dist_v - last_dist : 0;
        if (dist_v == last_dist) tl = prev_time;
        last_dist = 14'(dist_v);
        prev_time = 24'(tl);
        if (ms == 0) begin
            spd = up ? 9999 : 0;
            cad = 999;
        end else begin
            s = dd * 3600000 / ms;
            c = longint'(e.crank) * 60000 / ms;
            c5 = (c / 5 + ((c % 10) >= 5 ? 1 : 0)) * 5;
            spd = s > 9999 ? 9999 : int'(s);
            cad = c5 > 999 ? 999 : int'(c5);
        end
        case (mode_r)
            bcde_pkg::MODE_ODO: begin iv = int'(dist_v / 100); fv = int'(dist_v % 100); end
            bcde_pkg::MODE_DUR: begin iv = tl / 3600; fv = (tl % 3600) / 60; end
            bcde_pkg::MODE_SPD: begin iv = spd / 100; fv = spd % 100; end
            default: begin iv = cad; fv = 0; end
        endcase
        push(mode_r, iv, fv, clr);
    endfunction

    function void note_event(event_t e);
        int h, t, o;
        if (editing) begin
            if (!e.req) return;
            if (e.mode) begin
                digit = digit + 2'd1;
                if (digit == 3) begin
                    editing = 0;
                    digit = 0;
                    display_refresh(e, 0);
                end
                return;
            end
            if (e.trip) begin
                h = (wheel % 1000) / 100; t = (wheel / 10) % 10; o = wheel % 10;
                if (digit == 0) h = (h + 1) % 10;
                else if (digit == 1) t = (t + 1) % 10;
                else o = (o + 1) % 10;
                wheel = h * 100 + t * 10 + o;
                push(bcde_pkg::MODE_SET, wheel, 0, 0);
            end
            return;
        end
        if (e.req) begin
            if (e.set) begin
                editing = 1;
                digit = 0;
                push(bcde_pkg::MODE_SET, wheel, 0, 0);
                return;
            end
            if (e.trip) begin
                display_refresh(e, 1);
                return;
            end
            if (e.mode)
                mode_r = (mode_r >= bcde_pkg::MODE_CAD || mode_r < bcde_pkg::MODE_ODO) ?
                         bcde_pkg::MODE_ODO : mode_r + 4'd1;
            else if (e.night)
                night_r = ~night_r;
        end
        display_refresh(e, 0);
    endfunction

    function void check_display(disp_t got);
        disp_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.mode !== want.mode) begin
            $display("%0t: mode expected %h actual %h", $time, want.mode, got.mode);
            errors++;
        end
        if (got.ibcd !== want.ibcd) begin
            $display("%0t: int_bcd expected %h actual %h", $time, want.ibcd, got.ibcd);
            errors++;
        end
        if (got.fbcd !== want.fbcd) begin
            $display("%0t: frac_bcd expected %h actual %h", $time, want.fbcd, got.fbcd);
            errors++;
        end
        if (got.clr_fork !== want.clr_fork) begin
            $display("%0t: wheel count clear expected %b actual %b", $time, want.clr_fork,
                     got.clr_fork);
            errors++;
        end
        if (got.clr_trip !== want.clr_trip) begin
            $display("%0t: clear_trip_time expected %b actual %b", $time, want.clr_trip,
                     got.clr_trip);
            errors++;
        end
        if (got.night !== want.night) begin
            $display("%0t: night_on expected %b actual %b", $time, want.night, got.night);
            errors++;
        end
    endfunction
endclass

module bike_computer_display_engine_top_tb;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [11:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    event_t      ev;
    logic        out_valid;
    logic        out_stall;
    disp_t       res;
    int          send_idle;
    int          recv_stall;
    int          hold_cycles;

    display_scoreboard sb;

    bike_computer_display_engine_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(ev.req), .i_btn_setting(ev.set), .i_btn_trip(ev.trip),
        .i_btn_mode(ev.mode), .i_btn_night(ev.night),
        .i_fork_count(ev.fork_cnt), .i_crank_count(ev.crank),
        .i_time_long_s(ev.tlong), .i_time_short_ms(ev.tshort),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_display_mode(res.mode), .o_int_bcd(res.ibcd), .o_frac_bcd(res.fbcd),
        .o_clear_wheel_cnt(res.clr_fork), .o_clear_trip_time(res.clr_trip),
        .o_night_on(res.night)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_display(res);
        if (hold_cycles > 0) begin
            out_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    task automatic send_event(event_t e);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        ev <= e;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_event(e);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_girth(logic [11:0] g);
        drain();
        cfg_we <= 1;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we <= 0;
        sb.girth = g;
    endtask

    function automatic event_t rand_event();
        event_t e;
        int sel;
        e.req = $urandom_range(99) < 70;
        sel = $urandom_range(99);
        e.set = sel < 8;
        e.trip = $urandom_range(99) < 15;
        e.mode = $urandom_range(99) < 35;
        e.night = $urandom_range(99) < 20;
        case ($urandom_range(3))
            0: e.fork_cnt = 20'($urandom_range(1048575));
            1: e.fork_cnt = 20'($urandom_range(2000));
            default: e.fork_cnt = 20'(sb.last_dist * 10000 / (sb.girth == 0 ? 1 : sb.girth)
                                      + $urandom_range(60));
        endcase
        e.crank = 10'($urandom);
        e.tlong = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(40000));
        case ($urandom_range(7))
            0: e.tshort = 0;
            1: e.tshort = 16'($urandom);
            default: e.tshort = 16'($urandom_range(5000, 1));
        endcase
        return e;
    endfunction

    function automatic event_t mk(logic r, logic s, logic t, logic m, logic n,
                                  logic [19:0] f, logic [9:0] c, logic [23:0] tl,
                                  logic [15:0] ts);
        event_t e;
        e = '{r, s, t, m, n, f, c, tl, ts};
        return e;
    endfunction

    initial begin
        logic [11:0] girths [5];
        sb = new();
        girths = '{12'd1, 12'd4095, 12'd2136, 12'd700, 12'd3000};
        rst_n = 0; cfg_we = 0; cfg_wdata = 0; in_valid = 0; ev = '0;
        out_stall = 0; send_idle = 0; recv_stall = 0; hold_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_event(mk(0, 0, 0, 0, 0, 0, 0, 0, 1000));
        send_event(mk(0, 0, 0, 0, 0, 20'hFFFFF, 10'h3FF, 24'hFFFFFF, 16'hFFFF));
        send_event(mk(0, 0, 0, 0, 0, 20'hFFFFF, 10'h3FF, 24'hFFFFFF, 0));
        send_event(mk(1, 0, 0, 1, 0, 20'hFFFFF, 0, 24'hFFFFFF, 1));
        send_event(mk(1, 0, 0, 1, 0, 100, 10'h3FF, 7200, 0));
        send_event(mk(1, 0, 0, 0, 0, 200, 10'h3FF, 9000, 1));
        send_event(mk(1, 0, 0, 1, 0, 5000, 17, 100, 1000));
        send_event(mk(1, 0, 0, 1, 1, 10, 0, 5, 1000));
        send_event(mk(1, 0, 0, 0, 1, 10, 0, 5, 1000));
        send_event(mk(1, 0, 1, 1, 1, 900, 5, 500, 700));
        send_event(mk(1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_event(mk(1, 1, 1, 1, 1, 1, 1, 1, 1));
        send_event(mk(0, 0, 0, 0, 0, 1, 1, 1, 1));
        send_event(mk(1, 0, 1, 0, 0, 1, 1, 1, 1));
        send_event(mk(1, 0, 0, 0, 1, 1, 1, 1, 1));
        send_event(mk(1, 0, 0, 1, 0, 1, 1, 1, 1));
        send_event(mk(1, 0, 1, 0, 0, 1, 1, 1, 1));
        send_event(mk(1, 0, 1, 1, 0, 1, 1, 1, 1));
        send_event(mk(1, 0, 1, 0, 0, 1, 1, 1, 1));
        send_event(mk(1, 0, 0, 1, 0, 3000, 90, 4000, 2000));
        for (int ph = 0; ph < 5; ph++) begin
            write_girth(girths[ph]);
            case (ph)
                1: begin send_idle = 80; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 80; end
                3: begin send_idle = 35; recv_stall = 35; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            if (ph == 0) hold_cycles = 600;
            for (int i = 0; i < 220; i++) begin
                send_event(rand_event());
                if (i == 110) drain();
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
